// ===== rtl/ahd_pkg.sv =====
// Shared definitions for the allpass/Householder input diffuser.
// Holds default sizes, register indexes, reset values, the polarity table,
// the sequencer state type and the control bundles. No dependencies.
package ahd_pkg;

	localparam int LANES_DEF       = 8;
	localparam int STAGES_DEF      = 4;
	localparam int MAX_DELAY_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int COEFF_W    = 15;
	localparam int DELAY_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int NREGDELAY  = 4;
	localparam int POL_COLS   = 8;

	localparam logic [COEFF_W-1:0] COEFF_RST       = 15'd20480;
	localparam logic [DELAY_W-1:0] STAGE_DELAY_RST [NREGDELAY] =
		'{10'd142, 10'd107, 10'd379, 10'd277};

	// Bit l of a row is set where lane l is negated in that stage.
	localparam logic [POL_COLS-1:0] POL_NEG [NREGDELAY] =
		'{8'b1101_0010, 8'b1011_0100, 8'b0110_1001, 8'b1010_0110};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF        = 3'd0,
		REG_STAGE0_DELAY = 3'd1,
		REG_STAGE1_DELAY = 3'd2,
		REG_STAGE2_DELAY = 3'd3,
		REG_STAGE3_DELAY = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SUBV,
		ST_MULV,
		ST_OUTY,
		ST_SUM,
		ST_DIV,
		ST_APPLY,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic mul_h;
		logic sub_v;
		logic mul_v;
		logic out_y;
	} lane_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} mix_ctl_t;

endpackage

// ===== rtl/ahd_lane.sv =====
// One lane of the diffuser: per-stage delay lines, allpass holds and the
// shared coefficient multiplier. Depends on ahd_pkg.
module ahd_lane
	import ahd_pkg::*;
#(
	parameter int LANE_IDX    = 0,
	parameter int STAGES      = STAGES_DEF,
	parameter int MAX_DELAY   = MAX_DELAY_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  lane_ctl_t                                    ctl,
	input  logic [((STAGES > 1) ? $clog2(STAGES) : 1)-1:0] stage,
	input  logic [$clog2(MAX_DELAY)-1:0]                 rd_ptr,
	input  logic [$clog2(MAX_DELAY)-1:0]                 wr_ptr,
	input  logic                                         rd_valid,
	input  logic [COEFF_W-1:0]                           coeff,
	input  logic signed [SAMPLE_BITS-1:0]                x,
	output logic signed [SAMPLE_BITS-1:0]                y
);

	localparam int SB   = SAMPLE_BITS;
	localparam int SW   = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int AW   = $clog2(MAX_DELAY);
	localparam int PW   = SB + COEFF_W + 1;
	localparam int SATW = SB + 3;

	function automatic logic signed [SB-1:0] sat(input logic signed [SATW-1:0] a);
		logic in_range;
		in_range = (a[SATW-1:SB-1] == '0) || (a[SATW-1:SB-1] == '1);
		if (in_range)
			return a[SB-1:0];
		return {a[SATW-1], {(SB-1){~a[SATW-1]}}};
	endfunction

	logic signed [SB-1:0] mem [2**(SW+AW)];
	logic signed [SB-1:0] rd_q;
	logic                 rdv_q;
	logic signed [SB-1:0] hold_q [STAGES];
	logic signed [PW-1:0] prod_q;
	logic signed [SB-1:0] v_q;
	logic signed [SB-1:0] y_q;

	logic signed [SB-1:0]   h;
	logic signed [SB-1:0]   mul_op;
	logic signed [PW-1:0]   rsum;
	logic signed [SB:0]     cm;
	logic signed [SB-1:0]   y_pos;
	logic signed [SB-1:0]   y_sel;
	logic                   neg;

	assign h      = hold_q[stage];
	assign mul_op = ctl.mul_h ? h : v_q;
	// Products are rounded half up to the sample grid.
	assign rsum   = prod_q + PW'(16384);
	assign cm     = (SB+1)'(rsum >>> COEFF_W);
	assign neg    = POL_NEG[2'(int'(stage) % NREGDELAY)][LANE_IDX % POL_COLS];
	assign y_pos  = sat(SATW'(h) + SATW'(cm));
	assign y_sel  = neg ? sat(-SATW'(y_pos)) : y_pos;
	assign y      = y_q;

	always_ff @(posedge clk) begin
		if (ctl.out_y)
			mem[{stage, wr_ptr}] <= v_q;
		if (ctl.mul_h) begin
			rd_q  <= mem[{stage, rd_ptr}];
			rdv_q <= rd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_h || ctl.mul_v)
			prod_q <= $signed({1'b0, coeff}) * mul_op;
		if (ctl.sub_v)
			v_q <= sat(SATW'(x) - SATW'(cm));
		if (ctl.out_y)
			y_q <= y_sel;
	end

	// A line slot never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < STAGES; s++)
				hold_q[s] <= '0;
		end else if (ctl.out_y) begin
			hold_q[stage] <= rdv_q ? rd_q : '0;
		end
	end

endmodule

// ===== rtl/ahd_mix.sv =====
// Householder merge: sums the lanes, divides by the lane count through a
// reciprocal multiplication and subtracts the term. Uses ahd_pkg.
module ahd_mix
	import ahd_pkg::*;
#(
	parameter int LANES       = LANES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  mix_ctl_t                            ctl,
	input  logic [LANES-1:0][SAMPLE_BITS-1:0]   y,
	output logic [LANES-1:0][SAMPLE_BITS-1:0]   mixed
);

	localparam int SB   = SAMPLE_BITS;
	localparam int SATW = SB + 3;
	localparam int LW   = $clog2(LANES);
	localparam int SUMW = SB + LW + 1;
	localparam int UW   = SB + LW + 2;
	localparam int MW   = UW + 1;
	localparam int PRW  = UW + MW;
	localparam int RSH  = UW + LW;
	localparam int QW   = PRW - RSH;
	// ceil(2^RSH / LANES) gives the exact floor quotient for any dividend below 2^UW.
	localparam longint RECIP =
		((longint'(1) << RSH) + longint'(LANES) - 1) / longint'(LANES);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

	function automatic logic signed [SB-1:0] sat(input logic signed [SATW-1:0] a);
		logic in_range;
		in_range = (a[SATW-1:SB-1] == '0) || (a[SATW-1:SB-1] == '1);
		if (in_range)
			return a[SB-1:0];
		return {a[SATW-1], {(SB-1){~a[SATW-1]}}};
	endfunction

	logic [UW-1:0]          num_q;
	logic [QW-1:0]          quo_q;

	logic signed [SUMW-1:0] sum;
	logic signed [UW:0]     n_full;
	logic [PRW-1:0]         prod;
	logic signed [SB+1:0]   q;

	always_comb begin
		sum = '0;
		for (int l = 0; l < LANES; l++)
			sum = sum + SUMW'($signed(y[l]));
	end

	// The dividend is biased by LANES * 2^SB so that it is never negative;
	// the quotient is unbiased again by subtracting 2^SB.
	assign n_full = ((UW+1)'(sum) <<< 1) + (UW+1)'(LANES / 2)
		+ ((UW+1)'(LANES) <<< SB);

	assign prod = PRW'(num_q) * PRW'(RECIP_M);

	always_ff @(posedge clk) begin
		if (ctl.load)
			num_q <= n_full[UW-1:0];
		if (ctl.step)
			quo_q <= prod[PRW-1:RSH];
	end

	assign q = (SB+2)'($signed({1'b0, quo_q}) - $signed((QW+1)'(1) << SB));

	always_comb begin
		for (int l = 0; l < LANES; l++)
			mixed[l] = sat(SATW'($signed(y[l])) - SATW'(q));
	end

endmodule

// ===== rtl/allpass_householder_diffuser.sv =====
// Eight-lane allpass diffuser with Householder mixing, top level.
// Holds the configuration registers, the frame sequencer, the shared write
// pointer and the output register. Uses ahd_pkg, ahd_lane and ahd_mix.
//
// Usage: one transfer on the s_axis channel carries a frame of LANES signed
// samples; one transfer on the m_axis channel returns the diffused frame.
// The frame runs through STAGES stages. Each stage runs the lane steps
// (delay line read and coefficient product, subtraction, second product,
// output and line write), then the lane sum, the reciprocal multiplication
// that divides by the lane count, and applying the mix. The output register
// is loaded in the finishing state after the last stage and s_axis_tready
// returns in the same cycle; no new frame is taken before then. s_axis_tready
// is high while the sequencer is idle, also while a finished frame waits in
// the output register. If the receiver stalls, the next frame runs to
// completion and then holds until the output register is taken. Reset clears
// configuration to defaults, the holds and the write pointer. Unwritten
// delay-line slots read as zero through a fill mark, so no clearing pass is
// needed. Configuration must be written only while the block is idle; the
// user is bound to this, as the block itself does not enforce it.
module allpass_householder_diffuser
	import ahd_pkg::*;
#(
	parameter int LANES       = LANES_DEF,
	parameter int STAGES      = STAGES_DEF,
	parameter int MAX_DELAY   = MAX_DELAY_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wen,
	input  logic [CFG_IDX_W-1:0]                   cfg_addr,
	input  logic [CFG_DATA_W-1:0]                  cfg_wdata,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// in_lane0 .. in_lane(LANES-1), SAMPLE_BITS each, from bit 0 up.
	input  logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// out_lane0 .. out_lane(LANES-1), SAMPLE_BITS each, from bit 0 up.
	output logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

	localparam int SB      = SAMPLE_BITS;
	localparam int DW      = ((LANES * SAMPLE_BITS + 7) / 8) * 8;
	localparam int SW      = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int AW      = $clog2(MAX_DELAY);

	function automatic logic [AW-1:0] reduce_delay(input logic [DELAY_W-1:0] d);
		logic [31:0] r;
		r = 32'(d);
		for (int k = 3; k >= 0; k--) begin
			if (r >= (32'(MAX_DELAY) << k))
				r = r - (32'(MAX_DELAY) << k);
		end
		return AW'(r);
	endfunction

	state_t state_q, state_nxt;

	logic [COEFF_W-1:0]            coeff_q;
	logic [AW-1:0]                 delay_q [NREGDELAY];
	logic [AW-1:0]                 wp_q;
	logic                          wrapped_q;
	logic [SW-1:0]                 stage_q;
	logic [LANES-1:0][SB-1:0]      lane_q;
	logic [LANES-1:0][SB-1:0]      out_q;
	logic                          out_valid_q;

	lane_ctl_t                     lane_ctl;
	mix_ctl_t                      mix_ctl;
	logic                          in_xfer;
	logic                          out_load;
	logic [AW-1:0]                 dsel;
	logic [AW-1:0]                 rd_ptr;
	logic                          rd_valid;
	logic [LANES-1:0][SB-1:0]      y_vec;
	logic [LANES-1:0][SB-1:0]      mixed;

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DW'(out_q);

	// Read pointer: write pointer minus the stage delay, modulo the line length.
	assign dsel   = delay_q[2'(int'(stage_q) % NREGDELAY)];
	assign rd_ptr = (wp_q >= dsel) ? (wp_q - dsel)
		: AW'((AW+1)'(wp_q) + (AW+1)'(MAX_DELAY) - (AW+1)'(dsel));
	// Before the pointer has wrapped, only slots below it hold written samples.
	assign rd_valid = wrapped_q || (rd_ptr < wp_q);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_xfer) state_nxt = ST_READ;
			ST_READ:   state_nxt = ST_SUBV;
			ST_SUBV:   state_nxt = ST_MULV;
			ST_MULV:   state_nxt = ST_OUTY;
			ST_OUTY:   state_nxt = ST_SUM;
			ST_SUM:    state_nxt = ST_DIV;
			ST_DIV:    state_nxt = ST_APPLY;
			ST_APPLY: begin
				if (stage_q == SW'(STAGES - 1))
					state_nxt = ST_FINISH;
				else
					state_nxt = ST_READ;
			end
			ST_FINISH: if (!out_valid_q || m_axis_tready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		lane_ctl.mul_h = (state_q == ST_READ);
		lane_ctl.sub_v = (state_q == ST_SUBV);
		lane_ctl.mul_v = (state_q == ST_MULV);
		lane_ctl.out_y = (state_q == ST_OUTY);
		mix_ctl.load   = (state_q == ST_SUM);
		mix_ctl.step   = (state_q == ST_DIV);
		s_axis_tready  = (state_q == ST_IDLE);
		out_load       = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			coeff_q     <= COEFF_RST;
			for (int i = 0; i < NREGDELAY; i++)
				delay_q[i] <= reduce_delay(STAGE_DELAY_RST[i]);
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wen) begin
				unique case (cfg_reg_t'(cfg_addr))
					REG_COEFF:        coeff_q    <= cfg_wdata[COEFF_W-1:0];
					REG_STAGE0_DELAY: delay_q[0] <= reduce_delay(cfg_wdata[DELAY_W-1:0]);
					REG_STAGE1_DELAY: delay_q[1] <= reduce_delay(cfg_wdata[DELAY_W-1:0]);
					REG_STAGE2_DELAY: delay_q[2] <= reduce_delay(cfg_wdata[DELAY_W-1:0]);
					REG_STAGE3_DELAY: delay_q[3] <= reduce_delay(cfg_wdata[DELAY_W-1:0]);
					default: ;
				endcase
			end
			if (in_xfer)
				stage_q <= '0;
			else if (state_q == ST_APPLY && stage_q != SW'(STAGES - 1))
				stage_q <= stage_q + 1'b1;
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (wp_q == AW'(MAX_DELAY - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			lane_q <= s_axis_tdata[LANES*SB-1:0];
		else if (state_q == ST_APPLY)
			lane_q <= mixed;
		if (out_load)
			out_q <= lane_q;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		ahd_lane #(
			.LANE_IDX    (l),
			.STAGES      (STAGES),
			.MAX_DELAY   (MAX_DELAY),
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl),
			.stage    (stage_q),
			.rd_ptr   (rd_ptr),
			.wr_ptr   (wp_q),
			.rd_valid (rd_valid),
			.coeff    (coeff_q),
			.x        (lane_q[l]),
			.y        (y_vec[l])
		);
	end

	ahd_mix #(
		.LANES       (LANES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mix (
		.clk   (clk),
		.ctl   (mix_ctl),
		.y     (y_vec),
		.mixed (mixed)
	);

endmodule

// ===== bench/allpass_householder_diffuser_test.sv =====
// Self-checking bench for the eight-lane allpass/Householder diffuser.
// Drives frames over the stream ports; checks each returned frame against a typed
// result or an in-bench fixed-point predictor. Depends on ahd_pkg and the diffuser RTL.
module allpass_householder_diffuser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ahd_pkg::*;

	localparam int NLANES  = LANES_DEF;
	localparam int NSTAGES = STAGES_DEF;
	localparam int DEPTH   = MAX_DELAY_DEF;
	localparam int SB      = SAMPLE_BITS_DEF;
	localparam int DW      = ((NLANES * SB + 7) / 8) * 8;

	localparam longint SAT_HI     = (longint'(1) << (SB - 1)) - 1;
	localparam longint SAT_LO     = -SAT_HI - 1;
	localparam longint COEFF_ONE  = longint'(1) << COEFF_W;
	localparam longint COEFF_HALF = longint'(1) << (COEFF_W - 1);

	localparam int COEFF_DEFAULT = 20480;
	localparam int DELAY_DEFAULT [NREGDELAY] = '{142, 107, 379, 277};

	// Bit l of a row is set where lane l has negative polarity in that stage.
	localparam logic [7:0] NEG_LANES [4] = '{8'hD2, 8'hB4, 8'h69, 8'hA6};

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	localparam int FRAME_CYCLES = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int REPORT_MAX   = 10;

	localparam logic [SB-1:0] S_MAX  = {1'b0, {(SB - 1){1'b1}}};
	localparam logic [SB-1:0] S_MIN  = {1'b1, {(SB - 1){1'b0}}};
	localparam logic [SB-1:0] S_ZERO = '0;
	localparam logic [SB-1:0] S_LSB  = 1;
	localparam logic [SB-1:0] S_NEG  = '1;
	localparam logic [DW-1:0] ZERO_FRAME = '0;

	typedef struct packed {
		logic          typed;
		logic [DW-1:0] frame;
		logic [DW-1:0] want;
	} vector_t;

	// Lane 0 is the rightmost sample of each frame. Only all-zero traffic from
	// the cleared state has a result that is obvious without the predictor.
	localparam vector_t DIRECTED [17] = '{
		'{1'b1, ZERO_FRAME, ZERO_FRAME},
		'{1'b0, {NLANES{S_MAX}}, ZERO_FRAME},
		'{1'b0, {NLANES{S_MIN}}, ZERO_FRAME},
		'{1'b0, {4{S_MIN, S_MAX}}, ZERO_FRAME},
		'{1'b0, {4{S_MAX, S_MIN}}, ZERO_FRAME},
		'{1'b0, {{7{S_ZERO}}, S_MAX}, ZERO_FRAME},
		'{1'b0, {S_MIN, {7{S_ZERO}}}, ZERO_FRAME},
		'{1'b0, {NLANES{S_NEG}}, ZERO_FRAME},
		'{1'b0, {NLANES{S_LSB}}, ZERO_FRAME},
		'{1'b0, {NLANES{24'h555555}}, ZERO_FRAME},
		'{1'b0, {NLANES{24'hAAAAAA}}, ZERO_FRAME},
		'{1'b0, {24'h700000, 24'h500000, 24'h300000, 24'h100000,
			24'hF00000, 24'hD00000, 24'hB00000, 24'h900000}, ZERO_FRAME},
		'{1'b0, ZERO_FRAME, ZERO_FRAME},
		'{1'b0, {NLANES{S_MAX}}, ZERO_FRAME},
		'{1'b0, {NLANES{S_MIN}}, ZERO_FRAME},
		'{1'b0, {S_MIN, S_MAX, S_NEG, S_LSB, S_ZERO, S_MAX, S_MIN, S_ZERO}, ZERO_FRAME},
		'{1'b0, ZERO_FRAME, ZERO_FRAME}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [DW-1:0]         s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [DW-1:0]         m_axis_tdata;

	// Predictor state.
	logic signed [SB-1:0] line_store [NSTAGES * NLANES * DEPTH];
	logic signed [SB-1:0] hold_store [NSTAGES * NLANES];
	int                   write_slot;
	logic [COEFF_W-1:0]   coeff_now;
	logic [DELAY_W-1:0]   delay_now [NREGDELAY];

	logic [DW-1:0] expected_frames [$];
	int            mismatch_count = 0;
	int            frames_seen = 0;
	int            quiet_cycles = 0;
	int            tx_idle_pct = 0;
	int            rx_idle_pct = 0;
	int            rx_hold_left = 0;

	allpass_householder_diffuser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint floor_div(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint clamp(longint x);
		if (x > SAT_HI)
			return SAT_HI;
		if (x < SAT_LO)
			return SAT_LO;
		return x;
	endfunction

	function automatic longint scale(longint s);
		return floor_div(longint'(coeff_now) * s + COEFF_HALF, COEFF_ONE);
	endfunction

	function automatic void clear_predictor();
		foreach (line_store[i])
			line_store[i] = '0;
		foreach (hold_store[i])
			hold_store[i] = '0;
		write_slot = 0;
		coeff_now = COEFF_DEFAULT;
		foreach (delay_now[i])
			delay_now[i] = DELAY_DEFAULT[i];
	endfunction

	// Runs one frame through all stages and advances the shared write slot.
	function automatic logic [DW-1:0] diffuse_frame(logic [DW-1:0] frame);
		longint        lane [NLANES];
		longint        h, delayed, v, y, sum, q;
		int            d, rp, hi;
		logic [DW-1:0] result;
		result = '0;
		for (int l = 0; l < NLANES; l++)
			lane[l] = longint'(signed'(frame[l * SB +: SB]));
		for (int s = 0; s < NSTAGES; s++) begin
			d = int'(delay_now[s % NREGDELAY]) % DEPTH;
			rp = (write_slot + DEPTH - d) % DEPTH;
			sum = 0;
			for (int l = 0; l < NLANES; l++) begin
				hi = s * NLANES + l;
				h = hold_store[hi];
				// With a zero delay the read hits the slot written below, so read first.
				delayed = line_store[hi * DEPTH + rp];
				v = clamp(lane[l] - scale(h));
				y = clamp(h + scale(v));
				hold_store[hi] = delayed[SB-1:0];
				line_store[hi * DEPTH + write_slot] = v[SB-1:0];
				if (NEG_LANES[s % 4][l % 8])
					y = clamp(-y);
				lane[l] = y;
			end
			for (int l = 0; l < NLANES; l++)
				sum = sum + lane[l];
			q = floor_div(2 * sum + NLANES / 2, NLANES);
			for (int l = 0; l < NLANES; l++)
				lane[l] = clamp(lane[l] - q);
		end
		write_slot = (write_slot + 1) % DEPTH;
		for (int l = 0; l < NLANES; l++)
			result[l * SB +: SB] = lane[l][SB-1:0];
		return result;
	endfunction

	// Mostly moderate audio levels so the lines carry real signal, with full-scale
	// noise and rail values mixed in.
	function automatic logic [DW-1:0] random_frame();
		logic [DW-1:0] frame;
		int            pick;
		frame = '0;
		for (int l = 0; l < NLANES; l++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				frame[l * SB +: SB] = SB'($urandom_range(0, 2 << 20) - (1 << 20));
			else if (pick < 85)
				frame[l * SB +: SB] = SB'($urandom);
			else
				case ($urandom_range(0, 3))
					0: frame[l * SB +: SB] = S_MAX;
					1: frame[l * SB +: SB] = S_MIN;
					2: frame[l * SB +: SB] = S_ZERO;
					default: frame[l * SB +: SB] = S_NEG;
				endcase
		end
		return frame;
	endfunction

	function automatic void note_failure(string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("ERROR: %s", what);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		case (addr)
			REG_COEFF: coeff_now = data[COEFF_W-1:0];
			REG_STAGE0_DELAY, REG_STAGE1_DELAY, REG_STAGE2_DELAY, REG_STAGE3_DELAY:
				delay_now[addr - REG_STAGE0_DELAY] = data[DELAY_W-1:0];
			default: ;
		endcase
	endtask

	// Upper data bits of the delay writes carry junk that the register drops.
	task automatic set_config(input int coeff, input int d0, input int d1, input int d2,
			input int d3);
		int d [NREGDELAY];
		d = '{d0, d1, d2, d3};
		write_reg(REG_COEFF, CFG_DATA_W'(coeff));
		for (int i = 0; i < NREGDELAY; i++)
			write_reg(CFG_IDX_W'(REG_STAGE0_DELAY + i),
				CFG_DATA_W'(($urandom_range(0, 31) << DELAY_W) | d[i]));
		write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
			CFG_DATA_W'($urandom));
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic send_frame(input logic [DW-1:0] frame, input logic typed,
			input logic [DW-1:0] want);
		logic [DW-1:0] predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= frame;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = diffuse_frame(frame);
		expected_frames.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (FRAME_CYCLES) @(posedge clk);
	endtask

	task automatic stream_frames(input int count, input int hold_at, input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				rx_hold_left = HOLD_CYCLES;
			if (i == pause_at)
				wait_drained();
			send_frame(random_frame(), 1'b0, ZERO_FRAME);
		end
	endtask

	// Receiver: random back-pressure, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left = rx_hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		logic [DW-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_frames.size() == 0) begin
				note_failure($sformatf("frame %0d arrived with nothing pending: %h",
					frames_seen, m_axis_tdata));
			end else begin
				want = expected_frames.pop_front();
				for (int l = 0; l < NLANES; l++)
					if (m_axis_tdata[l * SB +: SB] !== want[l * SB +: SB])
						note_failure($sformatf("frame %0d lane %0d: expected %0d, got %0d",
							frames_seen, l, $signed(want[l * SB +: SB]),
							$signed(m_axis_tdata[l * SB +: SB])));
			end
			frames_seen++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clear_predictor();
		tx_idle_pct = 16;
		rx_idle_pct = 65;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_frame(DIRECTED[i].frame, DIRECTED[i].typed, DIRECTED[i].want);
		wait_drained();

		// Short delays so the lines feed back quickly; the receiver stalls long once.
		set_config($urandom_range(1, 32766), 1, 5, 17, 64);
		stream_frames(300, 120, -1);
		wait_drained();

		tx_idle_pct = 65;
		rx_idle_pct = 16;
		set_config(32767, $urandom_range(1, 200), $urandom_range(1, 200),
			$urandom_range(1, 1023), $urandom_range(1, 1023));
		stream_frames(300, -1, 150);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_config(COEFF_DEFAULT, $urandom_range(1, 1023), $urandom_range(1, 1023),
			$urandom_range(1, 1023), $urandom_range(1, 1023));
		stream_frames(250, -1, -1);
		wait_drained();

		// The write slot wraps during this run, so a zero delay and the longest delay
		// first read never-written slots as zero, then samples from the previous pass.
		set_config(0, 1023, 0, 1, $urandom_range(0, 1023));
		stream_frames(300, -1, -1);
		wait_drained();

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== allpass_householder_diffuser.f =====
rtl/ahd_pkg.sv
rtl/ahd_lane.sv
rtl/ahd_mix.sv
rtl/allpass_householder_diffuser.sv
bench/allpass_householder_diffuser_test.sv
